/* sv/bcpe_pkg.sv */
// shared types, constants and polynomial coefficient tables of the charge estimator
package bcpe_pkg;

    localparam int ADC_W     = 12;
    localparam int GAIN_W    = 24;
    localparam int V_W       = 32;
    localparam int V_FRAC    = 28;
    localparam int V_SHIFT   = 4;
    localparam int PCT_W     = 7;
    localparam int MV_W      = 14;
    localparam int ACC_W     = 64;
    localparam int FRAC_BITS = 39;
    localparam int NCOEF     = 7;
    localparam int NSTEP     = NCOEF - 1;
    localparam int COEF_IDX_W = $clog2(NCOEF);
    // init stage, then abs / multiply / reduce / add for each horner step
    localparam int NSTG      = 1 + 4 * NSTEP;
    localparam int Q_DEPTH   = 4;

    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam logic REG_GAIN = 1'b0;   // register index, byte address bit 2
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd3460301;

    // 3.675f in q4.28
    localparam logic [V_W-1:0] V_THRESH = 32'd986500288;
    localparam logic [9:0] MV_SCALE  = 10'd1000;
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [V_W-1:0]  v;
        logic            sel;
        logic [MV_W-1:0] mv;
    } t_item;

    // decimal coefficients to q24.39, round half away from zero on the magnitude
    localparam logic [127:0] P9  = 128'd1000000000;
    localparam logic [127:0] P10 = 128'd10000000000;
    localparam logic [127:0] P11 = 128'd100000000000;
    localparam logic [127:0] P12 = 128'd1000000000000;
    localparam logic [127:0] P13 = 128'd10000000000000;
    localparam logic [127:0] P14 = 128'd100000000000000;

    localparam logic [127:0] LO_Q0 = ((128'd7654079395955621  << 40) + P14) / (P14 << 1);
    localparam logic [127:0] LO_Q1 = ((128'd15177707491201104 << 40) + P13) / (P13 << 1);
    localparam logic [127:0] LO_Q2 = ((128'd12529852043810739 << 40) + P12) / (P12 << 1);
    localparam logic [127:0] LO_Q3 = ((128'd5512114598520336  << 40) + P11) / (P11 << 1);
    localparam logic [127:0] LO_Q4 = ((128'd1362835582523768  << 40) + P10) / (P10 << 1);
    localparam logic [127:0] LO_Q5 = ((128'd17955385891177552 << 40) + P11) / (P11 << 1);
    localparam logic [127:0] LO_Q6 = ((128'd984825318346571   << 40) + P10) / (P10 << 1);

    localparam logic [127:0] HI_Q0 = ((128'd6483050941489363  << 40) + P13) / (P13 << 1);
    localparam logic [127:0] HI_Q1 = ((128'd1568335414488613  << 40) + P11) / (P11 << 1);
    localparam logic [127:0] HI_Q2 = ((128'd158018994634744   << 40) + P9)  / (P9 << 1);
    localparam logic [127:0] HI_Q3 = ((128'd848783248894731   << 40) + P9)  / (P9 << 1);
    localparam logic [127:0] HI_Q4 = ((128'd25634331126427907 << 40) + P10) / (P10 << 1);
    localparam logic [127:0] HI_Q5 = ((128'd4127225955897427  << 40) + P9)  / (P9 << 1);
    localparam logic [127:0] HI_Q6 = ((128'd27675354085456543 << 40) + P10) / (P10 << 1);

    // highest power first
    localparam logic [ACC_W-1:0] COEF_LO [NCOEF] = '{
        LO_Q0[ACC_W-1:0],
        ~LO_Q1[ACC_W-1:0] + 64'd1,
        LO_Q2[ACC_W-1:0],
        ~LO_Q3[ACC_W-1:0] + 64'd1,
        LO_Q4[ACC_W-1:0],
        ~LO_Q5[ACC_W-1:0] + 64'd1,
        LO_Q6[ACC_W-1:0]
    };

    localparam logic [ACC_W-1:0] COEF_HI [NCOEF] = '{
        ~HI_Q0[ACC_W-1:0] + 64'd1,
        HI_Q1[ACC_W-1:0],
        ~HI_Q2[ACC_W-1:0] + 64'd1,
        HI_Q3[ACC_W-1:0],
        ~HI_Q4[ACC_W-1:0] + 64'd1,
        HI_Q5[ACC_W-1:0],
        ~HI_Q6[ACC_W-1:0] + 64'd1
    };

    function automatic logic [ACC_W-1:0] coef_at(input logic sel,
                                                 input logic [COEF_IDX_W-1:0] idx);
        return sel ? COEF_HI[idx] : COEF_LO[idx];
    endfunction

endpackage

/* sv/bcpe_front.sv */
// front end: voltage scaling, range select and millivolt conversion
module bcpe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [bcpe_pkg::ADC_W-1:0]  i_adc_sample,
    input  logic [bcpe_pkg::GAIN_W-1:0] i_gain,
    output logic                        o_valid,
    output bcpe_pkg::t_item             o_item,
    input  logic                        i_q_full
);
    import bcpe_pkg::*;

    localparam int PROD_W = ADC_W + GAIN_W;
    localparam int MVP_W  = V_W + 10;

    logic               r_vld1;
    logic [V_W-1:0]     r_v1;
    logic               r_vld2;
    t_item              r_item2;

    logic               s1_ready;
    logic               s2_ready;
    logic [PROD_W-1:0]  v_prod;
    logic [MVP_W-1:0]   mv_prod;

    assign s2_ready = !r_vld2 || !i_q_full;
    assign s1_ready = !r_vld1 || s2_ready;
    assign o_full   = !s1_ready;
    assign o_valid  = r_vld2;
    assign o_item   = r_item2;

    // q0.32 gain times count, q4.28 after the shift
    assign v_prod  = PROD_W'(i_adc_sample) * PROD_W'(i_gain);
    // below 16000 for any 32-bit voltage, so the top bits never overflow
    assign mv_prod = MVP_W'(r_v1) * MVP_W'(MV_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_vld1 <= i_push;
            end
            if (s2_ready) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_push) begin
            r_v1 <= v_prod[V_SHIFT +: V_W];
        end
        if (s2_ready && r_vld1) begin
            r_item2.v   <= r_v1;
            r_item2.sel <= (r_v1 > V_THRESH);
            r_item2.mv  <= mv_prod[V_FRAC +: MV_W];
        end
    end

endmodule

/* sv/bcpe_queue.sv */
// short item queue between front end and polynomial pipeline
module bcpe_queue #(
    parameter int DEPTH = bcpe_pkg::Q_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bcpe_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output bcpe_pkg::t_item o_item,
    input  logic            i_pop
);
    import bcpe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* sv/bcpe_back.sv */
// back end: pipelined horner evaluation, clamp, percent scaling and result register
module bcpe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  bcpe_pkg::t_item            i_item,
    output logic                       o_take,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [bcpe_pkg::PCT_W-1:0] o_charge_percent,
    output logic [bcpe_pkg::MV_W-1:0]  o_battery_millivolts
);
    import bcpe_pkg::*;

    localparam int PPROD_W = FRAC_BITS + 1 + PCT_W;

    logic               en;

    logic [NSTG-1:0]    r_vld;
    t_item              r_side [NSTG];

    logic [ACC_W-1:0]   r_acc   [NSTEP+1];
    logic               r_neg_a [NSTEP];
    logic [ACC_W-1:0]   r_mag   [NSTEP];
    logic               r_neg_m [NSTEP];
    logic [ACC_W-1:0]   r_phi   [NSTEP];
    logic [ACC_W-1:0]   r_plo   [NSTEP];
    logic               r_neg_s [NSTEP];
    logic [ACC_W-2:0]   r_red   [NSTEP];

    logic [ACC_W-1:0]   n_mag   [NSTEP];
    logic [ACC_W-1:0]   n_phi   [NSTEP];
    logic [ACC_W-1:0]   n_plo   [NSTEP];
    logic [ACC_W-2:0]   n_red   [NSTEP];
    logic [ACC_W-1:0]   n_acc   [NSTEP];

    logic               r_out_vld;
    logic [PCT_W-1:0]   r_pct;
    logic [MV_W-1:0]    r_mv;

    logic [FRAC_BITS:0] clamped;
    logic [PPROD_W-1:0] pct_prod;

    // whole pipeline moves together unless a finished result is held
    assign en      = !r_out_vld || i_pop;
    assign o_take  = en;
    assign o_empty = !r_out_vld;
    assign o_charge_percent     = r_pct;
    assign o_battery_millivolts = r_mv;

    always_comb begin
        logic [ACC_W-1:0] rsum;
        logic [ACC_W-1:0] coef;
        logic [ACC_W:0]   csum;
        logic [ACC_W:0]   cext;
        logic [ACC_W:0]   rext;
        for (int k = 0; k < NSTEP; k++) begin
            n_mag[k] = r_acc[k][ACC_W-1] ? (~r_acc[k] + 64'd1) : r_acc[k];
            n_phi[k] = ACC_W'(r_mag[k][ACC_W-1:32]) * ACC_W'(r_side[1 + 4*k].v);
            n_plo[k] = ACC_W'(r_mag[k][31:0]) * ACC_W'(r_side[1 + 4*k].v);
            // (mag * v) >> 28 from the two partial products, saturated
            rsum = (r_phi[k] << (32 - V_FRAC)) + (r_plo[k] >> V_FRAC);
            if (r_phi[k][ACC_W-1:59] != '0 || rsum[ACC_W-1]) begin
                n_red[k] = '1;
            end else begin
                n_red[k] = rsum[ACC_W-2:0];
            end
            coef = coef_at(r_side[3 + 4*k].sel, COEF_IDX_W'(k + 1));
            cext = {coef[ACC_W-1], coef};
            rext = {2'b00, r_red[k]};
            csum = r_neg_s[k] ? (cext - rext) : (cext + rext);
            if (csum[ACC_W] != csum[ACC_W-1]) begin
                n_acc[k] = csum[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                n_acc[k] = csum[ACC_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_acc[NSTEP][ACC_W-1]) begin
            clamped = '0;
        end else if (r_acc[NSTEP] > ACC_W'(ONE_Q)) begin
            clamped = ONE_Q;
        end else begin
            clamped = r_acc[NSTEP][FRAC_BITS:0];
        end
        pct_prod = PPROD_W'(clamped) * PPROD_W'(PCT_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NSTG-2:0], i_valid};
            r_out_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= i_item;
            r_acc[0]  <= coef_at(i_item.sel, '0);
            for (int j = 1; j < NSTG; j++) begin
                r_side[j] <= r_side[j-1];
            end
            for (int k = 0; k < NSTEP; k++) begin
                r_neg_a[k]  <= r_acc[k][ACC_W-1];
                r_mag[k]    <= n_mag[k];
                r_neg_m[k]  <= r_neg_a[k];
                r_phi[k]    <= n_phi[k];
                r_plo[k]    <= n_plo[k];
                r_neg_s[k]  <= r_neg_m[k];
                r_red[k]    <= n_red[k];
                r_acc[k+1]  <= n_acc[k];
            end
            if (r_vld[NSTG-1]) begin
                r_pct <= pct_prod[FRAC_BITS +: PCT_W];
                r_mv  <= r_side[NSTG-1].mv;
            end
        end
    end

endmodule

/* sv/battery_charge_percent_estimator_top.sv */
// top level of the battery charge estimator: config register and front/queue/back wiring
//
// Turns a 12-bit battery ADC sample into a charge percentage (0..100) and the
// battery voltage in millivolts. The sample is scaled by the volts-per-count
// gain register (unsigned q0.32, byte address 0, reset 3460301 = 3.3 V / 4096)
// to a q4.28 voltage; above 3.675 V the high-range polynomial is used,
// otherwise the low-range one. Both are degree six, evaluated by horner's rule
// with q24.39 coefficients in a saturating 64-bit accumulator, then clamped to
// 0..1 and scaled by 100 with truncation. One item is taken per clock and one
// result leaves per clock when pop keeps up. On its way to the output an item
// passes two front stages, the queue, 25 stages of the horner pipeline (four
// per multiply-add step, each step using two 32x32 partial products) and the
// result register. The pipeline halts as a whole while a result waits to be
// popped; the four-entry queue and front stages keep taking items until they
// fill. The gain should only be written while no item is in flight.
module battery_charge_percent_estimator_top #(
    parameter int Q_DEPTH = bcpe_pkg::Q_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item side
    input  logic                          push,
    output logic                          full,
    input  logic [bcpe_pkg::ADC_W-1:0]    i_adc_sample,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output logic [bcpe_pkg::PCT_W-1:0]    o_charge_percent,
    output logic [bcpe_pkg::MV_W-1:0]     o_battery_millivolts,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcpe_pkg::APB_AW-1:0]   paddr,
    input  logic [bcpe_pkg::APB_DW-1:0]   pwdata,
    output logic [bcpe_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bcpe_pkg::*;

    logic [GAIN_W-1:0] r_gain;

    // front to queue
    logic   f_valid;
    t_item  f_item;
    logic   q_full;

    // queue to back
    logic   q_valid;
    t_item  q_item;
    logic   b_take;

    // register file: only the gain, word at byte address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAIN) ? APB_DW'(r_gain) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAIN) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    // scale to volts, pick range, convert to millivolts
    bcpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_adc_sample (i_adc_sample),
        .i_gain       (r_gain),
        .o_valid      (f_valid),
        .o_item       (f_item),
        .i_q_full     (q_full)
    );

    // decouples the front end from pipeline stalls
    bcpe_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (b_take)
    );

    // polynomial pipeline and result register
    bcpe_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (q_valid),
        .i_item               (q_item),
        .o_take               (b_take),
        .o_empty              (empty),
        .i_pop                (pop),
        .o_charge_percent     (o_charge_percent),
        .o_battery_millivolts (o_battery_millivolts)
    );

endmodule

/* sv/bcpe_checker.sv */
// port-level checks of the charge estimator, bound to the top level
module bcpe_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [bcpe_pkg::PCT_W-1:0] o_charge_percent,
    input logic [bcpe_pkg::MV_W-1:0]  o_battery_millivolts
);
    import bcpe_pkg::*;

    // no result may be shown right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown after reset");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_charge_percent <= PCT_W'(100)))
        else $error("charge percent above 100");

    // a 32-bit q4.28 voltage stays below 16000 mV
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_battery_millivolts < MV_W'(16000)))
        else $error("millivolts out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_charge_percent)
                              && $stable(o_battery_millivolts)))
        else $error("waiting result changed");

endmodule

bind battery_charge_percent_estimator_top bcpe_checker u_bcpe_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .empty                (empty),
    .pop                  (pop),
    .o_charge_percent     (o_charge_percent),
    .o_battery_millivolts (o_battery_millivolts)
);

/* bench/battery_charge_percent_estimator_top_tb.sv */
// self-checking testbench of the battery charge estimator top level
module battery_charge_percent_estimator_top_tb;

    // polynomial range select, the same as the block's knee decision
    localparam int LOW_RANGE  = 0;
    localparam int HIGH_RANGE = 1;
    localparam int N_COEF     = 7;

    // 3.675f in q4.28, the knee between the two curves
    localparam logic [31:0] VOLT_KNEE_Q28 = 32'd986500288;
    localparam logic signed [63:0] ONE_Q39 = 64'sd1 << 39;
    localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] I64_MIN = {1'b1, {63{1'b0}}};
    localparam logic [13:0] MV_CEIL = 14'd16383;

    // gain register, index 0 at byte address 0
    localparam logic [bcpe_pkg::APB_AW-1:0] GAIN_ADDR = {bcpe_pkg::REG_GAIN, 2'b00};
    localparam logic [bcpe_pkg::GAIN_W-1:0] GAIN_AT_RESET = 24'd3460301;
    localparam logic [bcpe_pkg::GAIN_W-1:0] GAIN_MAX = {bcpe_pkg::GAIN_W{1'b1}};
    // with this gain a sample of 1024 lands exactly on the knee
    localparam logic [bcpe_pkg::GAIN_W-1:0] GAIN_AT_KNEE = 24'd15414067;

    // cycles without any accepted transfer before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    // settle time after the last reading
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [bcpe_pkg::ADC_W-1:0] adc;
        logic [bcpe_pkg::PCT_W-1:0] pct;
        logic [bcpe_pkg::MV_W-1:0]  mv;
    } t_charge_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // item side
    logic push = 1'b0;
    logic full;
    logic [bcpe_pkg::ADC_W-1:0] i_adc_sample = '0;

    // result side
    logic empty;
    logic pop = 1'b0;
    logic [bcpe_pkg::PCT_W-1:0] o_charge_percent;
    logic [bcpe_pkg::MV_W-1:0]  o_battery_millivolts;

    // register port
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bcpe_pkg::APB_AW-1:0] paddr = '0;
    logic [bcpe_pkg::APB_DW-1:0] pwdata = '0;
    logic [bcpe_pkg::APB_DW-1:0] prdata;
    logic pready;

    // shadow of the gain register and the readings still owed by the block
    logic [bcpe_pkg::GAIN_W-1:0] gain_setting = GAIN_AT_RESET;
    t_charge_reading expected_readings[$];
    logic signed [63:0] coef_q39 [2][N_COEF];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int n_samples = 0;
    int n_readings = 0;
    int n_gains = 0;

    battery_charge_percent_estimator_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_adc_sample         (i_adc_sample),
        .empty                (empty),
        .pop                  (pop),
        .o_charge_percent     (o_charge_percent),
        .o_battery_millivolts (o_battery_millivolts),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // decimal mantissa over 10^digits into q24.39, ties away from zero
    function automatic logic signed [63:0] dec_to_q39(input bit neg,
                                                      input logic [63:0] mant,
                                                      input int digits);
        logic [127:0] div;
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] rem;
        div = 128'd1;
        for (int i = 0; i < digits; i++)
            div = div * 128'd10;
        num = {64'd0, mant} << 39;
        q = num / div;
        rem = num % div;
        if (rem >= div - rem)
            q = q + 128'd1;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // acc times voltage, back to q24.39 with the magnitude truncated, saturating
    function automatic logic signed [63:0] mul_volts(input logic signed [63:0] acc,
                                                     input logic [31:0] v);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] r;
        mag = acc[63] ? -acc : acc;
        prod = mag * v;
        r = prod >> 28;
        if (r > 128'h7FFF_FFFF_FFFF_FFFF)
            r = 128'h7FFF_FFFF_FFFF_FFFF;
        return acc[63] ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
            return s[64] ? I64_MIN : I64_MAX;
        return s[63:0];
    endfunction

    // full charge estimate of one sample at a given gain
    function automatic t_charge_reading estimate_charge(
            input logic [bcpe_pkg::ADC_W-1:0] adc,
            input logic [bcpe_pkg::GAIN_W-1:0] gain);
        t_charge_reading r;
        logic [35:0] raw;
        logic [31:0] v;
        logic signed [63:0] acc;
        logic [63:0] frac;
        logic [47:0] mv_wide;
        int range;
        raw = adc * gain;
        v = raw[35:4];
        range = (v > VOLT_KNEE_Q28) ? HIGH_RANGE : LOW_RANGE;
        acc = '0;
        for (int k = 0; k < N_COEF; k++)
            acc = sat_add(mul_volts(acc, v), coef_q39[range][k]);
        if (acc < 0)
            frac = '0;
        else if (acc > ONE_Q39)
            frac = ONE_Q39;
        else
            frac = acc;
        frac = (frac * 64'd100) >> 39;
        mv_wide = v * 48'd1000;
        mv_wide = mv_wide >> 28;
        r.adc = adc;
        r.pct = frac[bcpe_pkg::PCT_W-1:0];
        r.mv = (mv_wide > MV_CEIL) ? MV_CEIL : mv_wide[bcpe_pkg::MV_W-1:0];
        return r;
    endfunction

    // both curves, highest power first
    initial begin
        coef_q39[LOW_RANGE][0]  = dec_to_q39(1'b0, 64'd7654079395955621, 14);
        coef_q39[LOW_RANGE][1]  = dec_to_q39(1'b1, 64'd15177707491201104, 13);
        coef_q39[LOW_RANGE][2]  = dec_to_q39(1'b0, 64'd12529852043810739, 12);
        coef_q39[LOW_RANGE][3]  = dec_to_q39(1'b1, 64'd5512114598520336, 11);
        coef_q39[LOW_RANGE][4]  = dec_to_q39(1'b0, 64'd1362835582523768, 10);
        coef_q39[LOW_RANGE][5]  = dec_to_q39(1'b1, 64'd17955385891177552, 11);
        coef_q39[LOW_RANGE][6]  = dec_to_q39(1'b0, 64'd984825318346571, 10);
        coef_q39[HIGH_RANGE][0] = dec_to_q39(1'b1, 64'd6483050941489363, 13);
        coef_q39[HIGH_RANGE][1] = dec_to_q39(1'b0, 64'd1568335414488613, 11);
        coef_q39[HIGH_RANGE][2] = dec_to_q39(1'b1, 64'd158018994634744, 9);
        coef_q39[HIGH_RANGE][3] = dec_to_q39(1'b0, 64'd848783248894731, 9);
        coef_q39[HIGH_RANGE][4] = dec_to_q39(1'b1, 64'd25634331126427907, 10);
        coef_q39[HIGH_RANGE][5] = dec_to_q39(1'b0, 64'd4127225955897427, 9);
        coef_q39[HIGH_RANGE][6] = dec_to_q39(1'b1, 64'd27675354085456543, 10);
    end

    // receiver: pop held low for a random share of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // everything is sampled at the clock edge, before any nonblocking update;
    // accepted samples get their prediction, accepted readings are checked
    always @(posedge i_clk) begin : reading_monitor
        t_charge_reading want;
        if (i_rst_n) begin
            if (push && !full) begin
                expected_readings.push_back(estimate_charge(i_adc_sample, gain_setting));
                n_samples++;
            end
            if (pop && !empty) begin
                n_readings++;
                if (expected_readings.size() == 0) begin
                    $display("%0t: reading with none pending, got pct %0d mv %0d",
                             $time, o_charge_percent, o_battery_millivolts);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (o_charge_percent !== want.pct) begin
                        $display("%0t: charge_percent mismatch (adc %0d), expected %0d, got %0d",
                                 $time, want.adc, want.pct, o_charge_percent);
                        fail_count++;
                    end
                    if (o_battery_millivolts !== want.mv) begin
                        $display("%0t: battery_millivolts mismatch (adc %0d), expected %0d, got %0d",
                                 $time, want.adc, want.mv, o_battery_millivolts);
                        fail_count++;
                    end
                end
            end
            if ((push && !full) || (pop && !empty) || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // hang detector
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // one sample, with random sender gaps ahead of it
    task automatic send_sample(input logic [bcpe_pkg::ADC_W-1:0] adc);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_adc_sample <= adc;
        do @(posedge i_clk); while (full);
    endtask

    // stop sending and wait for every owed reading
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_readings.size() != 0);
    endtask

    task automatic read_gain(output logic [bcpe_pkg::APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= GAIN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        val = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the gain while idle, then read it straight back (psel stays high)
    task automatic set_gain(input logic [bcpe_pkg::GAIN_W-1:0] g);
        logic [bcpe_pkg::APB_DW-1:0] rd;
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GAIN_ADDR;
        pwdata <= bcpe_pkg::APB_DW'(g);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        gain_setting = g;
        n_gains++;
        read_gain(rd);
        if (rd[bcpe_pkg::GAIN_W-1:0] !== g) begin
            $display("%0t: gain readback mismatch, expected %0d, got %0d",
                     $time, g, rd[bcpe_pkg::GAIN_W-1:0]);
            fail_count++;
        end
    endtask

    // reset gain value and a few samples at the 3.3 V reference scale
    task automatic test_reset_gain();
        logic [bcpe_pkg::APB_DW-1:0] rd;
        read_gain(rd);
        if (rd[bcpe_pkg::GAIN_W-1:0] !== GAIN_AT_RESET) begin
            $display("%0t: reset gain mismatch, expected %0d, got %0d",
                     $time, GAIN_AT_RESET, rd[bcpe_pkg::GAIN_W-1:0]);
            fail_count++;
        end
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'h555);
        send_sample(12'hAAA);
        send_sample(12'd3000);
        wait_drained();
    endtask

    // just below, exactly on and just above the curve knee, then both ends of the scale
    task automatic test_knee();
        set_gain(GAIN_AT_KNEE);
        send_sample(12'd1023);
        send_sample(12'd1024);
        send_sample(12'd1025);
        send_sample(12'd0);
        send_sample(12'd4095);
        wait_drained();
    endtask

    // zero gain and full gain, the latter driving voltages near 16 V
    // and so the accumulator saturation and both clamps
    task automatic test_gain_extremes();
        set_gain('0);
        send_sample(12'd0);
        send_sample(12'd4095);
        set_gain(GAIN_MAX);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'd1500);
        send_sample(12'd700);
        wait_drained();
    endtask

    // random samples over a few gains under one idle mix
    task automatic test_random(input int idle_pct, input int stall_pct);
        logic [bcpe_pkg::GAIN_W-1:0] g;
        logic [bcpe_pkg::ADC_W-1:0] adc;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++) begin
            // mostly divider ratios that put full scale near 3..6 V,
            // sometimes any gain at all
            if ($urandom_range(3) == 0)
                g = bcpe_pkg::GAIN_W'($urandom_range(0, 24'hFFFFFF));
            else
                g = bcpe_pkg::GAIN_W'($urandom_range(3000000, 6500000));
            set_gain(g);
            for (int n = 0; n < 31; n++) begin
                if ($urandom_range(15) == 0)
                    adc = $urandom_range(1) ? 12'd4095 : 12'd0;
                else
                    adc = bcpe_pkg::ADC_W'($urandom_range(0, 4095));
                send_sample(adc);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs with no idling
        test_reset_gain();
        test_knee();
        test_gain_extremes();

        // random part: no idling, sender gaps, receiver stalls, both
        test_random(0, 0);
        test_random(50, 0);
        test_random(0, 50);
        test_random(32, 32);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d samples sent, %0d readings compared, %0d gain writes",
                 n_samples, n_readings, n_gains);
        $display("tb: knee, zero and full gain directed, random under four idle mixes");
        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0t: %0d errors, %0d readings missing",
                     $time, fail_count, expected_readings.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
sv/bcpe_pkg.sv
sv/bcpe_front.sv
sv/bcpe_queue.sv
sv/bcpe_back.sv
sv/battery_charge_percent_estimator_top.sv
sv/bcpe_checker.sv
bench/battery_charge_percent_estimator_top_tb.sv
